// ----- sv/autokey_shift_register_byte_cipher_defines.svh -----
// assertion macros used by the cipher engine rtl
`ifndef AUTOKEY_SHIFT_REGISTER_BYTE_CIPHER_DEFINES_SVH
`define AUTOKEY_SHIFT_REGISTER_BYTE_CIPHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AKC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define AKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/akc_pkg.sv -----
// types, constants and the per-byte cipher function
package akc_pkg;

  localparam int REG_W  = 24;
  localparam int IDX_W  = 5;
  localparam int DATA_W = 8;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [IDX_W-1:0]   TABLE_LEN    = 5'd20;
  localparam logic [REG_W-1:0]   RESTART_BASE = 24'hFFFF00;
  localparam logic [PADDR_W-1:0] SEED_ADDR    = 2'd0;

  typedef enum logic [1:0] {
    REQ_RESTART = 2'd0,
    REQ_ENCODE  = 2'd1,
    REQ_DECODE  = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [REG_W-1:0] sreg;
    logic [IDX_W-1:0] idx;
  } cipher_state_t;

  // low 24 bits of the key table words
  function automatic logic [REG_W-1:0] key_word(logic [IDX_W-1:0] idx);
    logic [REG_W-1:0] w;
    case (idx)
      5'd0:    w = 24'hcb5af2;
      5'd1:    w = 24'h564650;
      5'd2:    w = 24'he02ee6;
      5'd3:    w = 24'h227d34;
      5'd4:    w = 24'ha037a7;
      5'd5:    w = 24'h2161b3;
      5'd6:    w = 24'hef5096;
      5'd7:    w = 24'hfe0b5c;
      5'd8:    w = 24'h7037dd;
      5'd9:    w = 24'h0c64c9;
      5'd10:   w = 24'ha54103;
      5'd11:   w = 24'h8712d3;
      5'd12:   w = 24'h5815be;
      5'd13:   w = 24'h1d5c02;
      5'd14:   w = 24'h3a7908;
      5'd15:   w = 24'hac2447;
      5'd16:   w = 24'hcb4074;
      5'd17:   w = 24'h4e50ee;
      5'd18:   w = 24'h7977c3;
      5'd19:   w = 24'h9328ce;
      default: w = 24'hcb5af2;
    endcase
    return w;
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] n;
    n = (idx >= TABLE_LEN - 5'd1) ? '0 : idx + 5'd1;
    return n;
  endfunction

  // or in the sign-extended plaintext, then eight shift steps with table feedback
  function automatic cipher_state_t absorb(cipher_state_t cur, logic [DATA_W-1:0] plain);
    logic [REG_W-1:0] r;
    logic [IDX_W-1:0] idx;
    logic             top;
    cipher_state_t    nxt;
    r = cur.sreg | {16'h0000, plain};
    if (plain[DATA_W-1]) begin
      r = r | 24'hFFFF00;
    end
    idx = (cur.idx >= TABLE_LEN) ? '0 : cur.idx;
    for (int k = 0; k < DATA_W; k++) begin
      top = r[REG_W-1];
      r   = {r[REG_W-2:0], 1'b0};
      if (top) begin
        r   = r ^ key_word(idx);
        idx = idx_inc(idx);
      end
    end
    nxt.sreg = r;
    nxt.idx  = idx;
    return nxt;
  endfunction

  localparam cipher_state_t RESET_STATE =
    absorb(cipher_state_t'{sreg: RESTART_BASE, idx: 5'd0}, 8'h00);

endpackage

// ----- sv/akc_if.sv -----
// request and response channel interfaces
interface akc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface akc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

// ----- sv/akc_apb.sv -----
// apb register block holding the restart seed
module akc_apb (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [akc_pkg::PADDR_W-1:0]  paddr,
  input  logic [akc_pkg::PDATA_W-1:0]  pwdata,
  output logic [akc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [akc_pkg::REG_W-1:0]    seed
);
  import akc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == SEED_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (wr_en) begin
      seed <= pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == SEED_ADDR) begin
      prdata = {{(PDATA_W-REG_W){1'b0}}, seed};
    end
  end

endmodule

// ----- sv/akc_engine.sv -----
// input register, cipher state update and result register
module akc_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [akc_pkg::REG_W-1:0] seed,
  akc_req_if.sink                   req,
  akc_rsp_if.source                 rsp
);
  import akc_pkg::*;
  `include "autokey_shift_register_byte_cipher_defines.svh"

  logic                s1_valid;
  logic [1:0]          s1_type;
  logic [DATA_W-1:0]   s1_data;
  cipher_state_t       st;
  cipher_state_t       st_next;
  logic                o_valid;
  logic [DATA_W-1:0]   o_data;

  logic                has_result;
  logic                out_free;
  logic                s1_go;
  logic                in_acc;
  logic [DATA_W-1:0]   res;
  logic [DATA_W-1:0]   plain;

  assign res        = s1_data ^ st.sreg[15:8];
  assign has_result = (s1_type == REQ_ENCODE) || (s1_type == REQ_DECODE);
  assign out_free   = !o_valid || rsp.ready;
  assign s1_go      = s1_valid && (!has_result || out_free);
  assign req.ready  = !s1_valid || s1_go;
  assign in_acc     = req.valid && req.ready;
  assign plain      = (s1_type == REQ_ENCODE) ? s1_data : res;

  assign rsp.valid    = o_valid;
  assign rsp.data_out = o_data;

  always_comb begin
    st_next = st;
    case (s1_type)
      REQ_RESTART: st_next = absorb(cipher_state_t'{sreg: RESTART_BASE ^ seed, idx: '0},
                                    8'h00);
      REQ_ENCODE:  st_next = absorb(st, plain);
      REQ_DECODE:  st_next = absorb(st, plain);
      default:     st_next = st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
      st       <= RESET_STATE;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        st <= st_next;
      end
      if (s1_go && has_result) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_type <= req.req_type;
      s1_data <= req.data_in;
    end
    if (s1_go && has_result) begin
      o_data <= res;
    end
  end

  `AKC_ASSERT_IMPL(a_idx_range, 1'b1, st.idx < TABLE_LEN)
  `AKC_ASSERT_NEXT(a_result_lands, s1_go && has_result, o_valid)
  `AKC_ASSERT_NEXT(a_unused_keeps_state, s1_go && (s1_type == REQ_UNUSED), $stable(st))
  `AKC_ASSERT_IMPL(a_empty_takes, !s1_valid, req.ready)

endmodule

// ----- sv/autokey_shift_register_byte_cipher.sv -----
// an accepted word waits in the input register, then its result is registered and shown on rsp
// throughput: one word per cycle unless a result on rsp waits untaken; the eight-step state update is combinational
// restart and unused request words produce no result and never wait on rsp
// reset: synchronous, clears seed to zero and loads the primed state
// (0xffff00, index 0, then one zero-byte encode); both channels come up empty
module autokey_shift_register_byte_cipher (
  input  logic                         clk,
  input  logic                         rst,
  akc_req_if.sink                      req,
  akc_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [akc_pkg::PADDR_W-1:0]  paddr,
  input  logic [akc_pkg::PDATA_W-1:0]  pwdata,
  output logic [akc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import akc_pkg::*;

  logic [REG_W-1:0] seed;

  akc_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed)
  );

  akc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .seed (seed),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
